// ===== rtl/core/sccb_pkg.sv =====
// Shared types and constants for the SCCB transaction master.
package sccb_pkg;

  localparam int unsigned QUARTERS_PER_BIT = 4;

  // operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_VERIFY = 2'd3;

  // status codes
  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_OK     = 2'd1;
  localparam logic [1:0] ST_FAIL   = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  // frame segments (low three bits of the step code)
  localparam logic [2:0] SEG_IDLE  = 3'd0;
  localparam logic [2:0] SEG_START = 3'd1;
  localparam logic [2:0] SEG_ID    = 3'd2;
  localparam logic [2:0] SEG_SUB   = 3'd3;
  localparam logic [2:0] SEG_DATA  = 3'd4;
  localparam logic [2:0] SEG_READ  = 3'd5;
  localparam logic [2:0] SEG_STOP  = 3'd6;

  // passes (high three bits of the step code)
  localparam logic [2:0] PASS_WRITE = 3'd0;
  localparam logic [2:0] PASS_ADDR  = 3'd1;
  localparam logic [2:0] PASS_FETCH = 3'd2;

  localparam logic [3:0] START_TICKS   = 4'd7;
  localparam logic [3:0] STOP_TICKS    = 4'd10;
  localparam logic [3:0] BITS_PER_CELL = 4'd9;
  localparam logic [3:0] DATA_BITS     = 4'd8;

  // configuration register indexes
  localparam logic CFG_DEVICE_ID   = 1'b0;
  localparam logic CFG_RETRY_LIMIT = 1'b1;

  localparam logic [3:0] RETRY_LIMIT_RESET = 4'd5;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] sub_address;
    logic [7:0] write_data;
    logic       burst_first;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic [7:0] read_data;
    logic       read_valid;
    logic [1:0] status;
  } out_word_t;

endpackage

// ===== rtl/core/sccb_master_transactions.sv =====
// SCCB master: command and quarter-bit tick words in, bus levels and status out.
// The result word of an accepted input word is registered and valid in the next cycle.
// Throughput: one word per cycle unless a stalled full result register holds input;
// each bus step is one combinational pass from input handshake to result register.
// Reset (synchronous, rst_n low): idle, SCL/SDA high, device_id 0, retry limit 5.
module sccb_master_transactions (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  sccb_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output sccb_pkg::out_word_t out_word
);

  // configuration
  logic [7:0] device_id_r;
  logic [3:0] retry_limit_r;

  // transaction state
  logic [5:0] step_r,    step_nxt;
  logic [3:0] qc_r,      qc_nxt;
  logic [3:0] bi_r,      bi_nxt;
  logic [7:0] shift_r,   shift_nxt;
  logic [7:0] addr_r,    addr_nxt;
  logic [7:0] held_r,    held_nxt;
  logic [3:0] att_r,     att_nxt;
  logic [1:0] kind_r,    kind_nxt;
  logic       scl_r,     scl_nxt;
  logic       sda_r,     sda_nxt;

  // result register
  logic                out_valid_r;
  sccb_pkg::out_word_t out_word_r;

  logic [2:0] pass;
  logic [2:0] seg;
  logic [7:0] tx_byte;
  logic       wr_bit;
  logic       wr_val;
  logic [1:0] status;
  logic       rvalid;
  logic [7:0] rdata;
  logic       accept;

  // A new word is taken whenever the result register is empty or draining.
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign pass = step_r[5:3];
  assign seg  = step_r[2:0];

  // byte shifted out in the current write cell; R/W bit set only in the fetch pass
  always_comb begin
    case (seg)
      sccb_pkg::SEG_ID:  tx_byte = {device_id_r[7:1], pass == sccb_pkg::PASS_FETCH};
      sccb_pkg::SEG_SUB: tx_byte = addr_r;
      default:           tx_byte = held_r;
    endcase
  end

  // read cells drive only the NA bit; write cells drive bits 7..0 then release
  assign wr_bit = (seg == sccb_pkg::SEG_READ) ? (bi_r >= sccb_pkg::DATA_BITS)
                                              : (bi_r < sccb_pkg::DATA_BITS);
  assign wr_val = (seg == sccb_pkg::SEG_READ) ? 1'b1 : tx_byte[~bi_r[2:0]];

  always_comb begin
    step_nxt  = step_r;
    qc_nxt    = qc_r;
    bi_nxt    = bi_r;
    shift_nxt = shift_r;
    addr_nxt  = addr_r;
    held_nxt  = held_r;
    att_nxt   = att_r;
    kind_nxt  = kind_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    status    = sccb_pkg::ST_NONE;
    rvalid    = 1'b0;
    rdata     = 8'd0;

    if (in_word.operation == sccb_pkg::OP_TICK) begin
      if (step_r != 6'd0) begin
        if (pass > sccb_pkg::PASS_FETCH || seg == sccb_pkg::SEG_IDLE ||
            seg > sccb_pkg::SEG_STOP) begin
          // undefined step code: drop back to idle
          step_nxt = 6'd0;
        end else begin
          case (seg)
            sccb_pkg::SEG_START: begin
              if (qc_r == 4'd0) scl_nxt = 1'b1;
              if (qc_r == 4'd1) sda_nxt = 1'b1;
              if (qc_r == 4'd5) sda_nxt = 1'b0;
              if (qc_r == 4'd6) scl_nxt = 1'b0;
              if (qc_r == sccb_pkg::START_TICKS - 4'd1) begin
                step_nxt = {pass, sccb_pkg::SEG_ID};
                qc_nxt   = 4'd0;
                bi_nxt   = 4'd0;
              end else begin
                qc_nxt = qc_r + 4'd1;
              end
            end
            sccb_pkg::SEG_STOP: begin
              if (qc_r == 4'd0) sda_nxt = 1'b0;
              if (qc_r == 4'd1) scl_nxt = 1'b1;
              if (qc_r == 4'd2) sda_nxt = 1'b1;
              if (qc_r == sccb_pkg::STOP_TICKS - 4'd1) begin
                // end of stop + gap: chain the next pass or finish
                qc_nxt = 4'd0;
                bi_nxt = 4'd0;
                if (pass == sccb_pkg::PASS_WRITE) begin
                  if (kind_r == sccb_pkg::OP_VERIFY) begin
                    step_nxt = {sccb_pkg::PASS_ADDR, sccb_pkg::SEG_START};
                  end else begin
                    step_nxt = 6'd0;
                    status   = sccb_pkg::ST_OK;
                  end
                end else if (pass == sccb_pkg::PASS_ADDR) begin
                  step_nxt = {sccb_pkg::PASS_FETCH, sccb_pkg::SEG_START};
                end else begin
                  rvalid = 1'b1;
                  rdata  = shift_r;
                  if (kind_r != sccb_pkg::OP_VERIFY || shift_r == held_r) begin
                    step_nxt = 6'd0;
                    status   = sccb_pkg::ST_OK;
                  end else if (att_r < retry_limit_r) begin
                    att_nxt  = att_r + 4'd1;
                    step_nxt = {sccb_pkg::PASS_WRITE, sccb_pkg::SEG_START};
                  end else begin
                    step_nxt = 6'd0;
                    status   = sccb_pkg::ST_FAIL;
                  end
                end
              end else begin
                qc_nxt = qc_r + 4'd1;
              end
            end
            default: begin
              // one bit cell: SDA on quarter 0, SCL up on 1, down on the last
              if (qc_r == 4'd0 && wr_bit) sda_nxt = wr_val;
              if (qc_r == 4'd1) scl_nxt = 1'b1;
              if (qc_r >= 4'(sccb_pkg::QUARTERS_PER_BIT - 1)) begin
                scl_nxt = 1'b0;
                if (seg == sccb_pkg::SEG_READ && bi_r < sccb_pkg::DATA_BITS)
                  shift_nxt = {shift_r[6:0], in_word.sda_in};
                qc_nxt = 4'd0;
                bi_nxt = bi_r + 4'd1;
                if (bi_r + 4'd1 >= sccb_pkg::BITS_PER_CELL) begin
                  bi_nxt = 4'd0;
                  if (seg == sccb_pkg::SEG_ID) begin
                    if (pass == sccb_pkg::PASS_FETCH) begin
                      step_nxt  = {pass, sccb_pkg::SEG_READ};
                      shift_nxt = 8'd0;
                    end else begin
                      step_nxt = {pass, sccb_pkg::SEG_SUB};
                    end
                  end else if (seg == sccb_pkg::SEG_SUB) begin
                    step_nxt = (pass == sccb_pkg::PASS_WRITE) ?
                               {pass, sccb_pkg::SEG_DATA} : {pass, sccb_pkg::SEG_STOP};
                  end else begin
                    step_nxt = {pass, sccb_pkg::SEG_STOP};
                  end
                end
              end else begin
                qc_nxt = qc_r + 4'd1;
              end
            end
          endcase
        end
      end
    end else if (step_r != 6'd0) begin
      status = sccb_pkg::ST_REJECT;
    end else begin
      // command load; bus time does not advance on this word
      addr_nxt = in_word.burst_first ? in_word.sub_address : addr_r + 8'd1;
      held_nxt = in_word.write_data;
      kind_nxt = in_word.operation;
      att_nxt  = 4'd0;
      qc_nxt   = 4'd0;
      bi_nxt   = 4'd0;
      step_nxt = (in_word.operation == sccb_pkg::OP_READ) ?
                 {sccb_pkg::PASS_ADDR, sccb_pkg::SEG_START} :
                 {sccb_pkg::PASS_WRITE, sccb_pkg::SEG_START};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r   <= 8'd0;
      retry_limit_r <= sccb_pkg::RETRY_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sccb_pkg::CFG_DEVICE_ID:   device_id_r   <= cfg_data;
        sccb_pkg::CFG_RETRY_LIMIT: retry_limit_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 6'd0;
      qc_r    <= 4'd0;
      bi_r    <= 4'd0;
      shift_r <= 8'd0;
      addr_r  <= 8'd0;
      held_r  <= 8'd0;
      att_r   <= 4'd0;
      kind_r  <= 2'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
    end else if (accept) begin
      step_r  <= step_nxt;
      qc_r    <= qc_nxt;
      bi_r    <= bi_nxt;
      shift_r <= shift_nxt;
      addr_r  <= addr_nxt;
      held_r  <= held_nxt;
      att_r   <= att_nxt;
      kind_r  <= kind_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r.scl_out    <= scl_nxt;
      out_word_r.sda_out    <= sda_nxt;
      out_word_r.busy_res   <= (step_nxt != 6'd0);
      out_word_r.read_data  <= rdata;
      out_word_r.read_valid <= rvalid;
      out_word_r.status     <= status;
    end
  end

endmodule

// ===== bench/sccb_bus_checker.sv =====
`timescale 1ns / 1ps
// Checker for the SCCB master: bus predictor, expected-word queue and field compare.
module sccb_bus_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  sccb_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  sccb_pkg::out_word_t out_word,
  output int                  fail_count,
  output int                  backlog
);
  import sccb_pkg::*;

  // predicted block state
  logic [5:0] step_code;
  logic [3:0] quarter;
  logic [3:0] bit_pos;
  logic [7:0] rx_byte;
  logic [7:0] reg_addr;
  logic [7:0] tx_data;
  logic [3:0] tries;
  logic [1:0] cmd_op;
  logic       scl_lvl;
  logic       sda_lvl;
  logic [7:0] id_byte;
  logic [3:0] retry_cap;

  out_word_t bus_out;
  out_word_t bus_results_due[$];
  int        errs = 0;

  function automatic void open_segment(input logic [2:0] pass, input logic [2:0] seg);
    step_code = {pass, seg};
    quarter   = '0;
    bit_pos   = '0;
    if (seg == SEG_READ) rx_byte = '0;
  endfunction

  function automatic void close_transaction(input logic [1:0] code);
    step_code      = '0;
    quarter        = '0;
    bit_pos        = '0;
    bus_out.status = code;
  endfunction

  function automatic void wrap_pass(input logic [2:0] pass);
    if (pass == PASS_WRITE) begin
      if (cmd_op == OP_VERIFY) open_segment(PASS_ADDR, SEG_START);
      else close_transaction(ST_OK);
    end else if (pass == PASS_ADDR) begin
      open_segment(PASS_FETCH, SEG_START);
    end else begin
      bus_out.read_valid = 1'b1;
      bus_out.read_data  = rx_byte;
      if (cmd_op != OP_VERIFY || rx_byte == tx_data) begin
        close_transaction(ST_OK);
      end else if (tries < retry_cap) begin
        tries = tries + 1'b1;
        open_segment(PASS_WRITE, SEG_START);
      end else begin
        close_transaction(ST_FAIL);
      end
    end
  endfunction

  // one quarter of a bit cell; the ninth bit is the ack / NA slot
  function automatic void clock_bit(input logic [2:0] pass, input logic [2:0] seg,
                                    input logic sda_level);
    logic       drive;
    logic       level;
    logic [7:0] src;
    level = 1'b1;
    if (seg == SEG_READ) begin
      drive = (bit_pos >= DATA_BITS);
    end else begin
      drive = (bit_pos < DATA_BITS);
      if (seg == SEG_ID) src = {id_byte[7:1], pass == PASS_FETCH};
      else if (seg == SEG_SUB) src = reg_addr;
      else src = tx_data;
      if (drive) level = src[3'd7 - bit_pos[2:0]];
    end
    if (quarter == 4'd0 && drive) sda_lvl = level;
    if (quarter == 4'd1) scl_lvl = 1'b1;
    if (quarter >= QUARTERS_PER_BIT - 1) begin
      scl_lvl = 1'b0;
      if (seg == SEG_READ && bit_pos < DATA_BITS) rx_byte = {rx_byte[6:0], sda_level};
      quarter = '0;
      bit_pos = bit_pos + 1'b1;
      if (bit_pos >= BITS_PER_CELL) begin
        if (seg == SEG_ID) open_segment(pass, pass == PASS_FETCH ? SEG_READ : SEG_SUB);
        else if (seg == SEG_SUB) open_segment(pass, pass == PASS_WRITE ? SEG_DATA : SEG_STOP);
        else open_segment(pass, SEG_STOP);
      end
    end else begin
      quarter = quarter + 1'b1;
    end
  endfunction

  function automatic void advance_bus(input logic sda_level);
    logic [2:0] pass;
    logic [2:0] seg;
    pass = step_code[5:3];
    seg  = step_code[2:0];
    if (step_code == '0) return;
    if (pass > PASS_FETCH || seg == SEG_IDLE || seg > SEG_STOP) begin
      step_code = '0;
      return;
    end
    if (seg == SEG_START) begin
      if (quarter == 4'd0) scl_lvl = 1'b1;
      if (quarter == 4'd1) sda_lvl = 1'b1;
      if (quarter == 4'd5) sda_lvl = 1'b0;
      if (quarter == 4'd6) scl_lvl = 1'b0;
      quarter = quarter + 1'b1;
      if (quarter >= START_TICKS) open_segment(pass, SEG_ID);
    end else if (seg == SEG_STOP) begin
      if (quarter == 4'd0) sda_lvl = 1'b0;
      if (quarter == 4'd1) scl_lvl = 1'b1;
      if (quarter == 4'd2) sda_lvl = 1'b1;
      quarter = quarter + 1'b1;
      if (quarter >= STOP_TICKS) wrap_pass(pass);
    end else begin
      clock_bit(pass, seg, sda_level);
    end
  endfunction

  function automatic void model_word(input in_word_t w);
    bus_out = '0;
    if (w.operation == OP_TICK) begin
      advance_bus(w.sda_in);
    end else if (step_code != '0) begin
      bus_out.status = ST_REJECT;
    end else begin
      reg_addr = w.burst_first ? w.sub_address : reg_addr + 1'b1;
      tx_data  = w.write_data;
      cmd_op   = w.operation;
      tries    = '0;
      open_segment(w.operation == OP_READ ? PASS_ADDR : PASS_WRITE, SEG_START);
    end
    bus_out.scl_out  = scl_lvl;
    bus_out.sda_out  = sda_lvl;
    bus_out.busy_res = (step_code != '0);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      step_code = '0;
      quarter   = '0;
      bit_pos   = '0;
      rx_byte   = '0;
      reg_addr  = '0;
      tx_data   = '0;
      tries     = '0;
      cmd_op    = '0;
      scl_lvl   = 1'b1;
      sda_lvl   = 1'b1;
      id_byte   = '0;
      retry_cap = RETRY_LIMIT_RESET;
      bus_results_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DEVICE_ID) id_byte = cfg_data;
        else retry_cap = cfg_data[3:0];
      end
      if (in_valid && !in_stall) begin
        model_word(in_word);
        bus_results_due.push_back(bus_out);
      end
      if (out_valid && !out_stall) begin
        if (bus_results_due.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_word);
          errs++;
        end else begin
          want = bus_results_due.pop_front();
          check_field("scl_out", want.scl_out, out_word.scl_out);
          check_field("sda_out", want.sda_out, out_word.sda_out);
          check_field("busy_res", want.busy_res, out_word.busy_res);
          check_field("read_data", want.read_data, out_word.read_data);
          check_field("read_valid", want.read_valid, out_word.read_valid);
          check_field("status", want.status, out_word.status);
        end
      end
    end
    fail_count <= errs;
    backlog    <= bus_results_due.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the SCCB master: clock, reset, stimulus and verdict.
module tb_top;
  import sccb_pkg::*;

  localparam int LIMIT_CYCLES = 500_000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic      cfg_index = CFG_DEVICE_ID;
  logic [7:0] cfg_data = '0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  int fail_count;
  int backlog;
  int sent_count    = 0;   // input words accepted so far
  int outs_seen     = 0;   // result words accepted so far
  int last_idle_out = -1;  // index of the newest result word with busy low
  int stall_left    = 0;
  int cycles        = 0;
  bit idling        = 1'b1;

  sccb_master_transactions uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  sccb_bus_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Result side: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idling && rst_n && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Pacing monitor: lets stimulus see when the bus has gone idle again.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (!out_word.busy_res) last_idle_out <= outs_seen;
      outs_seen <= outs_seen + 1;
    end
  end

  // Watchdog.
  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Tick word; fields the block ignores on a tick get random values.
  function automatic in_word_t tick_word(input logic level);
    in_word_t w;
    w = '0;
    w.operation = OP_TICK;
    {w.sub_address, w.write_data} = $urandom_range(0, 65535);
    w.burst_first = $urandom_range(0, 1);
    w.sda_in = level;
    return w;
  endfunction

  function automatic in_word_t cmd_word(input logic [1:0] op, input logic [7:0] addr,
                                        input logic [7:0] data, input logic first);
    in_word_t w;
    w.operation   = op;
    w.sub_address = addr;
    w.write_data  = data;
    w.burst_first = first;
    w.sda_in      = $urandom_range(0, 1);
    return w;
  endfunction

  // Hold one word on the input until it is taken, with an optional gap first.
  task automatic send_word(input in_word_t w);
    if (idling && $urandom_range(0, 15) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Drop valid and wait for every result word to come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outs_seen != sent_count) @(posedge clk);
  endtask

  // Both registers, back to back; only called with the block idle.
  task automatic program_regs(input logic [7:0] id, input logic [3:0] cap);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEVICE_ID;
    cfg_data  <= id;
    @(posedge clk);
    cfg_index <= CFG_RETRY_LIMIT;
    cfg_data  <= {4'b0, cap};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One command, then ticks until a result word shows the bus idle again.
  // hold: drive sda_in at a fixed level (steers the read-back), else random.
  // poke: drop extra commands in while busy; they must be rejected.
  task automatic transaction(input logic [1:0] op, input logic [7:0] addr,
                             input logic [7:0] data, input logic first,
                             input bit hold, input logic level, input bit poke);
    int       cmd_idx;
    int       age;
    in_word_t w;
    cmd_idx = sent_count;
    send_word(cmd_word(op, addr, data, first));
    while (last_idle_out <= cmd_idx) begin
      age = sent_count - cmd_idx;
      // shortest transaction is 125 ticks, so anything under 100 is surely busy
      if (poke && age < 100 && (age == 3 || $urandom_range(0, 39) == 0))
        w = cmd_word($urandom_range(1, 3), $urandom, $urandom, $urandom_range(0, 1));
      else
        w = tick_word(hold ? level : logic'($urandom_range(0, 1)));
      send_word(w);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ticks while idle, then every command under reset config.
    send_word(tick_word(1'b0));
    send_word(tick_word(1'b1));
    transaction(OP_WRITE, 8'hFF, 8'h5A, 1'b1, 1'b0, 1'b0, 1'b1);
    transaction(OP_READ, 8'h12, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);   // address wraps to 00
    transaction(OP_VERIFY, 8'hC3, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0); // matches first try

    // One retry allowed: a verify that never matches fails after two attempts.
    // Last part of the run goes without idling.
    settle();
    program_regs(8'hFF, 4'd1);
    idling <= 1'b0;
    transaction(OP_VERIFY, 8'h7E, 8'hA5, 1'b1, 1'b1, 1'b0, 1'b1);

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && backlog == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
